### sv/sync_packet_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### sv/spd_pkg.sv
// Shared types and constants of the sync packet deframer.
`default_nettype none

package spd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned NUM_TYPES    = 4;
  localparam int unsigned NUM_SIZE_REGS = 4;
  localparam int unsigned SIZE_IDX_W   = $clog2(NUM_SIZE_REGS);
  localparam int unsigned CFG_IDX_W    = 8;

  localparam logic [BYTE_W-1:0] SYNC_FIRST     = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND    = 8'h55;
  localparam logic [BYTE_W-1:0] MIN_SIZE       = 8'd3;
  localparam logic [BYTE_W-1:0] BODY_START_POS = 8'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNKNOWN    = 2'd1,
    ST_WRONG_SIZE = 2'd2,
    ST_CHECKSUM   = 2'd3
  } status_e;

  typedef struct packed {
    status_e           status;
    logic              byte_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              packet_done;
    logic [1:0]        packet_type;
  } result_t;

endpackage

`default_nettype wire

### sv/spd_cfg_regs.sv
// Per-type expected packet size registers with id lookup.
`default_nettype none

module spd_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [spd_pkg::BYTE_W-1:0]    cfg_data_i,
  input  wire logic [spd_pkg::BYTE_W-1:0]    lookup_id_i,
  output logic      [spd_pkg::BYTE_W-1:0]    exp_size_o
);
  import spd_pkg::*;

  logic [BYTE_W-1:0] size_q [NUM_SIZE_REGS];

  // Drop writes to indexes beyond the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SIZE_REGS; i++) begin
        size_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_SIZE_REGS))) begin
      size_q[cfg_index_i[SIZE_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // Ids without a register expect size zero, so they always fail the size check.
  assign exp_size_o = (lookup_id_i < BYTE_W'(NUM_SIZE_REGS)) ?
                      size_q[lookup_id_i[SIZE_IDX_W-1:0]] : '0;

endmodule

`default_nettype wire

### sv/spd_parser.sv
// Deframing state machine: one byte per advance, result registered.
`default_nettype none

module spd_parser #(
  parameter int unsigned NUM_TYPES = spd_pkg::NUM_TYPES
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire logic [spd_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic [spd_pkg::BYTE_W-1:0] exp_size_i,
  output spd_pkg::result_t                result_o
);
  import spd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_SIZE  = 3'd3,
    PH_BODY  = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [1:0]        type_id_q, type_id_d;
  logic [BYTE_W-1:0] pos_q, pos_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  result_t           res_q, res_d;
  logic              last_byte;

  assign last_byte = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};

  always_comb begin
    phase_d   = phase_q;
    type_id_d = type_id_q;
    pos_d     = pos_q;
    len_d     = len_q;
    xor_d     = xor_q;
    res_d     = '0;
    res_d.status = ST_OK;
    case (phase_q)
      PH_SYNC2: begin
        if (rx_byte_i == SYNC_SECOND) begin
          phase_d = PH_ID;
        end else begin
          phase_d      = PH_HUNT;
          res_d.status = ST_UNKNOWN;
        end
      end
      PH_ID: begin
        if (rx_byte_i >= BYTE_W'(NUM_TYPES)) begin
          phase_d      = PH_HUNT;
          res_d.status = ST_UNKNOWN;
        end else begin
          type_id_d = rx_byte_i[1:0];
          len_d     = exp_size_i;
          xor_d     = rx_byte_i;
          phase_d   = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if ((rx_byte_i != len_q) || (rx_byte_i < MIN_SIZE)) begin
          phase_d      = PH_HUNT;
          res_d.status = ST_WRONG_SIZE;
        end else begin
          xor_d   = xor_q ^ rx_byte_i;
          pos_d   = BODY_START_POS;
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        xor_d            = xor_q ^ rx_byte_i;
        res_d.byte_valid = 1'b1;
        res_d.data_byte  = rx_byte_i;
        res_d.byte_index = pos_q;
        if (last_byte) begin
          phase_d = PH_HUNT;
          if (xor_d == '0) begin
            res_d.packet_done = 1'b1;
          end else begin
            res_d.status = ST_CHECKSUM;
          end
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
      default: begin
        if (rx_byte_i == SYNC_FIRST) begin
          phase_d = PH_SYNC2;
        end else begin
          phase_d      = PH_HUNT;
          res_d.status = ST_UNKNOWN;
        end
      end
    endcase
    res_d.packet_type = type_id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      type_id_q <= '0;
      pos_q     <= '0;
      len_q     <= '0;
      xor_q     <= '0;
      res_q     <= '0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      type_id_q <= type_id_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      xor_q     <= xor_d;
      res_q     <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

### sv/sync_packet_deframer.sv
// Top level of the sync packet deframer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | in        | in_valid_i / in_stall_o | rx_byte_i
//   out     | out       | out_valid_o/ out_stall_i| status_o, byte_valid_o,
//           |           |                         | data_byte_o, byte_index_o,
//           |           |                         | packet_done_o, packet_type_o
//   cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// A word is parsed into the free result register; one word per cycle is sustained
// without output stalls, set by the single parse step between the two registers.
// Reset (rst_ni low, asynchronous) empties both registers, restarts the sync hunt
// and clears the size registers.
// A stall on the output holds the result; the input register keeps taking one
// more word, then in_stall_o rises until the result is taken.
`default_nettype none

module sync_packet_deframer #(
  parameter int unsigned NUM_TYPES = spd_pkg::NUM_TYPES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [spd_pkg::BYTE_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [spd_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [1:0]                    status_o,
  output logic                               byte_valid_o,
  output logic      [spd_pkg::BYTE_W-1:0]    data_byte_o,
  output logic      [spd_pkg::BYTE_W-1:0]    byte_index_o,
  output logic                               packet_done_o,
  output logic      [1:0]                    packet_type_o
);
  import spd_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              out_valid_q, out_valid_d;
  logic              out_ready;
  logic              in_ready;
  logic              advance;
  logic              in_take;
  logic [BYTE_W-1:0] exp_size;
  result_t           result;

  // Advance a word into the result register whenever that register is free or
  // being emptied this cycle.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = in_valid_q && out_ready;
  assign in_ready  = !in_valid_q || advance;
  assign in_take   = in_valid_i && in_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the incoming word; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  spd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .lookup_id_i (in_byte_q),
    .exp_size_o  (exp_size)
  );

  spd_parser #(
    .NUM_TYPES (NUM_TYPES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .rx_byte_i  (in_byte_q),
    .exp_size_i (exp_size),
    .result_o   (result)
  );

  assign in_stall_o    = !in_ready;
  assign out_valid_o   = out_valid_q;
  assign status_o      = result.status;
  assign byte_valid_o  = result.byte_valid;
  assign data_byte_o   = result.data_byte;
  assign byte_index_o  = result.byte_index;
  assign packet_done_o = result.packet_done;
  assign packet_type_o = result.packet_type;

`include "sync_packet_deframer_assert.svh"

  // A finished packet is always a good body word.
  `SPD_ASSERT_NOW(a_done_is_ok, out_valid_o && packet_done_o, (status_o == ST_OK) && byte_valid_o)
  // Body words start at position two.
  `SPD_ASSERT_NOW(a_body_index, out_valid_o && byte_valid_o, byte_index_o >= BODY_START_POS)
  // Input backs up only behind a held result.
  `SPD_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  // With nothing queued, a taken result leaves the output empty.
  `SPD_ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !in_valid_q, !out_valid_o)

endmodule

`default_nettype wire

### verif/sync_packet_deframer_tb.sv
// Self-checking testbench of the sync packet deframer: byte streams checked against a local parser.
`timescale 1ns / 100ps

module sync_packet_deframer_tb;
  import spd_pkg::*;

  // Parser phases of the local model; codes past PH_BODY are never entered.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_ID,
    PH_SIZE,
    PH_BODY
  } rx_phase_e;

  // Block inputs start at known values; reset is held from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [BYTE_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    rx_byte_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           status_o;
  logic                 byte_valid_o;
  logic [BYTE_W-1:0]    data_byte_o;
  logic [BYTE_W-1:0]    byte_index_o;
  logic                 packet_done_o;
  logic [1:0]           packet_type_o;

  // Local copy of the size registers and of the parser state.
  logic [BYTE_W-1:0] size_reg [NUM_SIZE_REGS];
  rx_phase_e         rx_phase;
  logic [1:0]        pkt_type;
  logic [BYTE_W-1:0] body_pos;
  logic [BYTE_W-1:0] pkt_len;
  logic [BYTE_W-1:0] csum;

  // Results still owed by the block, oldest first.
  result_t pending_results [$];

  int mismatches   = 0;
  int bytes_sent   = 0;
  int src_gap_max  = 0;
  int sink_gap_max = 0;
  int sink_wait    = 0;
  int long_hold    = 0;

  sync_packet_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .byte_valid_o  (byte_valid_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .packet_done_o (packet_done_o),
    .packet_type_o (packet_type_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the parser by one received byte and return the result it owes.
  function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    r        = '0;
    r.status = ST_OK;
    case (rx_phase)
      PH_SYNC2: begin
        // A miss here restarts the hunt at the next byte, even for 0xAA.
        if (b == SYNC_SECOND) begin
          rx_phase = PH_ID;
        end else begin
          rx_phase = PH_HUNT;
          r.status = ST_UNKNOWN;
        end
      end
      PH_ID: begin
        if (b >= NUM_TYPES) begin
          rx_phase = PH_HUNT;
          r.status = ST_UNKNOWN;
        end else begin
          // Latch the expected size now; later register writes do not apply.
          pkt_type = b[1:0];
          pkt_len  = size_reg[b[1:0]];
          csum     = b;
          rx_phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (b != pkt_len || b < MIN_SIZE) begin
          rx_phase = PH_HUNT;
          r.status = ST_WRONG_SIZE;
        end else begin
          csum     = csum ^ b;
          body_pos = BODY_START_POS;
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        csum         = csum ^ b;
        r.byte_valid = 1'b1;
        r.data_byte  = b;
        r.byte_index = body_pos;
        if (int'(body_pos) + 1 >= int'(pkt_len)) begin
          // Last byte: the XOR over id, size and body must come out zero.
          rx_phase = PH_HUNT;
          if (csum == '0) begin
            r.packet_done = 1'b1;
          end else begin
            r.status = ST_CHECKSUM;
          end
        end else begin
          body_pos = body_pos + 8'd1;
        end
      end
      default: begin
        if (b == SYNC_FIRST) begin
          rx_phase = PH_SYNC2;
        end else begin
          rx_phase = PH_HUNT;
          r.status = ST_UNKNOWN;
        end
      end
    endcase
    r.packet_type = pkt_type;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
    mismatches++;
  endtask

  // Receiver: take each result word, check it against the oldest expectation,
  // then hold off for a random gap before taking the next one.
  // A long hold-off requested by a test is counted down here as well.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, status %h", $time, status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_field("status", 8'(want.status), 8'(status_o));
        if (byte_valid_o !== want.byte_valid)
          report_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid_o));
        if (data_byte_o !== want.data_byte)
          report_field("data_byte", want.data_byte, data_byte_o);
        if (byte_index_o !== want.byte_index)
          report_field("byte_index", want.byte_index, byte_index_o);
        if (packet_done_o !== want.packet_done)
          report_field("packet_done", 8'(want.packet_done), 8'(packet_done_o));
        if (packet_type_o !== want.packet_type)
          report_field("packet_type", 8'(want.packet_type), 8'(packet_type_o));
      end
      sink_wait = $urandom_range(0, sink_gap_max);
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    if (long_hold > 0) long_hold--;
    out_stall_i <= (sink_wait > 0) || (long_hold > 0);
  end

  // Offer one word after a random gap, wait for it to be taken, and record
  // the result it owes. Valid stays high when the next word follows at once.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(parse_byte(b));
    bytes_sent++;
  endtask

  // Stop offering words and wait until every owed result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write all four size registers, then one stray index that must be ignored.
  task automatic program_sizes(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [7:0] s2, input logic [7:0] s3);
    logic [7:0] vals [NUM_SIZE_REGS];
    int         i;
    vals = '{s0, s1, s2, s3};
    for (i = 0; i <= NUM_SIZE_REGS; i++) begin
      cfg_we_i <= 1'b1;
      if (i < NUM_SIZE_REGS) begin
        cfg_index_i <= CFG_IDX_W'(i);
        cfg_data_i  <= vals[i];
        size_reg[i] = vals[i];
      end else begin
        cfg_index_i <= CFG_IDX_W'($urandom_range(NUM_SIZE_REGS, 255));
        cfg_data_i  <= 8'($urandom_range(0, 255));
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Send a full packet of the given type at its configured size; the last
  // body byte zeroes the XOR unless the packet is to be corrupted.
  task automatic send_packet(input logic [1:0] id, input bit corrupt);
    logic [7:0] len;
    logic [7:0] acc;
    logic [7:0] b;
    int         i;
    len = size_reg[id];
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte({6'd0, id});
    send_byte(len);
    if (len >= MIN_SIZE) begin
      acc = {6'd0, id} ^ len;
      for (i = 0; i < int'(len) - 3; i++) begin
        b   = 8'($urandom_range(0, 255));
        acc = acc ^ b;
        send_byte(b);
      end
      if (corrupt) acc = acc ^ 8'($urandom_range(1, 255));
      send_byte(acc);
    end
  endtask

  // Mostly well-formed packets with random bodies, the rest broken headers
  // and line noise. Long configured sizes turn into size mismatches here.
  task automatic send_mixed_traffic(input int n_bytes);
    int         stop_at;
    int         pick;
    logic [1:0] id;
    logic [7:0] b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      id   = 2'($urandom_range(0, 3));
      if (pick < 75 && size_reg[id] > 8'd40) pick = 80;
      if (pick < 62) begin
        send_packet(id, 1'b0);
      end else if (pick < 75) begin
        send_packet(id, 1'b1);
      end else if (pick < 83) begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte({6'd0, id});
        do b = 8'($urandom_range(0, 255)); while (b == size_reg[id]);
        send_byte(b);
      end else if (pick < 89) begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'($urandom_range(NUM_TYPES, 255)));
      end else if (pick < 94) begin
        send_byte(SYNC_FIRST);
        do b = 8'($urandom_range(0, 255)); while (b == SYNC_SECOND);
        send_byte(b);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Hunt misses, a second 0xAA that is not retaken, an unknown id and a zero
  // size at reset; then a good packet, a checksum error and a size mismatch.
  task automatic test_directed();
    logic [7:0] at_reset [$];
    logic [7:0] configured [$];
    at_reset   = '{8'h00, 8'hFF, SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
                   SYNC_FIRST, SYNC_SECOND, 8'h04,
                   SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00};
    configured = '{SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h03, 8'h03,
                   SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h03, 8'h07,
                   SYNC_FIRST, SYNC_SECOND, 8'h01, 8'h05};
    src_gap_max  = 3;
    sink_gap_max = 3;
    foreach (at_reset[k]) send_byte(at_reset[k]);
    drain_results();
    program_sizes(8'd3, 8'd4, 8'd2, 8'd255);
    foreach (configured[k]) send_byte(configured[k]);
  endtask

  // Small packets with both sides idling at random.
  task automatic test_random_idle();
    drain_results();
    program_sizes(8'($urandom_range(3, 10)), 8'($urandom_range(3, 10)),
                  8'($urandom_range(3, 10)), 8'($urandom_range(3, 10)));
    src_gap_max  = 10;
    sink_gap_max = 10;
    send_mixed_traffic(270);
  endtask

  // Back-to-back words with no idling on either side.
  task automatic test_full_rate();
    drain_results();
    program_sizes(8'($urandom_range(3, 16)), 8'($urandom_range(3, 16)),
                  8'd3, 8'($urandom_range(0, 16)));
    src_gap_max  = 0;
    sink_gap_max = 0;
    send_mixed_traffic(260);
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // block fills and stalls its input; then pause the sender until all is in.
  task automatic test_backpressure();
    drain_results();
    program_sizes(8'd5, 8'd6, 8'd7, 8'd8);
    src_gap_max  = 0;
    sink_gap_max = 2;
    long_hold    = 150;
    send_mixed_traffic(60);
    drain_results();
    src_gap_max  = 2;
    sink_gap_max = 10;
    send_mixed_traffic(60);
  endtask

  // Largest size on type 0, smallest legal size on type 1, sizes that can
  // never pass on types 2 and 3; then random register values, types 1 and 3 at most 40.
  task automatic test_extreme_sizes();
    drain_results();
    program_sizes(8'd255, 8'd3, 8'd0, 8'd1);
    src_gap_max  = 2;
    sink_gap_max = 2;
    send_packet(2'd0, 1'b0);
    send_mixed_traffic(100);
    drain_results();
    program_sizes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(3, 40)));
    src_gap_max  = 10;
    sink_gap_max = 10;
    send_mixed_traffic(120);
  endtask

  initial begin
    foreach (size_reg[k]) size_reg[k] = '0;
    rx_phase = PH_HUNT;
    pkt_type = '0;
    body_pos = '0;
    pkt_len  = '0;
    csum     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_idle();
    test_full_rate();
    test_backpressure();
    test_extreme_sizes();
    drain_results();
    // Let any stray word surface before judging.
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sync_packet_deframer test passed");
    end else begin
      $display("sync_packet_deframer test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("sync_packet_deframer test failed");
    $finish;
  end

endmodule
